FILE: hdl/pst_pkg.sv
// Shared types and constants for the priority task scheduler.
package pst_pkg;

  // Default number of tasks and the id space that the fields allow.
  localparam int unsigned NUM_TASKS = 8;
  localparam int unsigned MAX_IDS   = 8;
  localparam int unsigned ID_W      = 3;
  localparam int unsigned CUR_W     = 4;
  localparam logic [CUR_W-1:0] NO_TASK = 4'd8;

  // Scheduler operation codes.
  typedef enum logic [2:0] {
    FUNC_ADD      = 3'd0,
    FUNC_SLEEP    = 3'd1,
    FUNC_WAIT     = 3'd2,
    FUNC_WAIT_TO  = 3'd3,
    FUNC_SET      = 3'd4,
    FUNC_TICK     = 3'd5,
    FUNC_RESCHED  = 3'd6,
    FUNC_COLLECT  = 3'd7
  } func_e;

  // Per-task run state.
  typedef enum logic [1:0] {
    ST_READY     = 2'd0,
    ST_WAIT_TIME = 2'd1,
    ST_WAIT_FLAG = 2'd2
  } tstate_e;

  // Request transaction.
  typedef struct packed {
    func_e             func;
    logic [ID_W-1:0]   task_id;
    logic [31:0]       event_mask;
    logic [31:0]       wait_time;
  } pst_req_t;

  // Result transaction.
  typedef struct packed {
    logic [ID_W-1:0] next_task;
    logic            switch_request;
    logic [31:0]     events;
  } pst_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic apply;
    logic load_ptr;
    logic dec_ptr;
    logic tick_step;
    logic pick_step;
    logic finish_sel;
    logic finish_nosel;
  } pst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_zero;
    logic ready_hit;
    logic no_select;
    logic is_tick;
  } pst_sts_t;

endpackage

FILE: hdl/pst_ctrl.sv
// Sequencing state machine of the priority task scheduler.
module pst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pst_pkg::pst_sts_t sts_i,
  output pst_pkg::pst_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_APPLY = 4'b0010,
    S_TICK  = 4'b0100,
    S_PICK  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        if (sts_i.no_select) begin
          cmd_o.finish_nosel = 1'b1;
          state_d            = S_IDLE;
        end else begin
          cmd_o.load_ptr = 1'b1;
          state_d        = sts_i.is_tick ? S_TICK : S_PICK;
        end
      end
      S_TICK: begin
        // Count down every timeout from the highest task to task 1.
        if (sts_i.ptr_zero) begin
          cmd_o.load_ptr = 1'b1;
          state_d        = S_PICK;
        end else begin
          cmd_o.tick_step = 1'b1;
          cmd_o.dec_ptr   = 1'b1;
        end
      end
      S_PICK: begin
        // Stop at the first ready task, or fall back to the idle task.
        cmd_o.pick_step = !sts_i.ptr_zero;
        if (sts_i.ptr_zero || sts_i.ready_hit) begin
          cmd_o.finish_sel = 1'b1;
          state_d          = S_IDLE;
        end else begin
          cmd_o.dec_ptr = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/pst_datapath.sv
// Task table, scan pointer and result register of the priority task scheduler.
module pst_datapath #(
  parameter int unsigned NumTasks = pst_pkg::NUM_TASKS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pst_pkg::pst_req_t req_i,
  input  pst_pkg::pst_cmd_t cmd_i,
  output pst_pkg::pst_sts_t sts_o,
  output logic              result_valid_o,
  output pst_pkg::pst_rsp_t rsp_o
);

  localparam int unsigned Depth =
    (NumTasks < pst_pkg::MAX_IDS) ? NumTasks : pst_pkg::MAX_IDS;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned IdW   = pst_pkg::ID_W;
  localparam int unsigned CurW  = pst_pkg::CUR_W;

  pst_pkg::pst_req_t req_q;
  logic [IdW-1:0]    ptr_q, ptr_d;
  logic [IdW-1:0]    highest_q, highest_d;
  logic [CurW-1:0]   cur_q, cur_d;
  logic              valid_q;
  pst_pkg::pst_rsp_t rsp_q, rsp_d;

  pst_pkg::tstate_e  state_q   [Depth];
  logic [31:0]       timeout_q [Depth];
  logic [31:0]       flags_q   [Depth];
  logic [31:0]       mask_q    [Depth];

  logic              has_cur, tid_ok, use_tid, we;
  logic [IdW-1:0]    cur_id, addr;
  logic [IdxW-1:0]   idx;
  pst_pkg::tstate_e  st_r, st_w;
  logic [31:0]       to_r, to_w, fl_r, fl_w, mk_r, mk_w;

  // Request register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
  end

  // Entry selection: operations address the target or current task, scans use the pointer.
  assign has_cur = (cur_q < CurW'(Depth));
  assign tid_ok  = ({1'b0, req_q.task_id} < CurW'(Depth));
  assign cur_id  = has_cur ? cur_q[IdW-1:0] : '0;
  assign use_tid = (req_q.func == pst_pkg::FUNC_ADD) || (req_q.func == pst_pkg::FUNC_SET);
  assign addr    = cmd_i.apply ? (use_tid ? req_q.task_id : cur_id) : ptr_q;
  assign idx     = addr[IdxW-1:0];

  assign st_r = state_q[idx];
  assign to_r = timeout_q[idx];
  assign fl_r = flags_q[idx];
  assign mk_r = mask_q[idx];

  // Status for the controller.
  assign sts_o.ptr_zero  = (ptr_q == '0);
  assign sts_o.ready_hit = (st_r == pst_pkg::ST_READY) ||
                           ((st_r == pst_pkg::ST_WAIT_FLAG) && ((fl_r & mk_r) != '0));
  assign sts_o.no_select = (req_q.func == pst_pkg::FUNC_ADD) ||
                           (req_q.func == pst_pkg::FUNC_COLLECT);
  assign sts_o.is_tick   = (req_q.func == pst_pkg::FUNC_TICK);

  // New contents of the selected entry.
  always_comb begin
    we        = 1'b0;
    st_w      = st_r;
    to_w      = to_r;
    fl_w      = fl_r;
    mk_w      = mk_r;
    highest_d = highest_q;
    if (cmd_i.apply) begin
      case (req_q.func)
        pst_pkg::FUNC_ADD: begin
          if (tid_ok) begin
            we   = 1'b1;
            st_w = pst_pkg::ST_READY;
            to_w = '0;
            fl_w = '0;
            mk_w = '0;
            if (req_q.task_id > highest_q) begin
              highest_d = req_q.task_id;
            end
          end
        end
        pst_pkg::FUNC_SLEEP: begin
          we   = has_cur;
          to_w = req_q.wait_time;
          st_w = pst_pkg::ST_WAIT_TIME;
        end
        pst_pkg::FUNC_WAIT, pst_pkg::FUNC_WAIT_TO: begin
          we   = has_cur;
          mk_w = req_q.event_mask;
          st_w = pst_pkg::ST_WAIT_FLAG;
          if (req_q.func == pst_pkg::FUNC_WAIT_TO) begin
            to_w = req_q.wait_time;
          end
        end
        pst_pkg::FUNC_SET: begin
          we   = tid_ok;
          fl_w = fl_r | req_q.event_mask;
        end
        pst_pkg::FUNC_COLLECT: begin
          we   = has_cur;
          fl_w = fl_r & ~mk_r;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else if (cmd_i.tick_step) begin
      // A running timeout counts down and readies the task when it expires.
      if (to_r != '0) begin
        we   = 1'b1;
        to_w = to_r - 32'd1;
        if (to_r == 32'd1) begin
          st_w = pst_pkg::ST_READY;
        end
      end
    end else if (cmd_i.pick_step) begin
      // A flag wait whose mask is met becomes ready during the scan.
      if ((st_r == pst_pkg::ST_WAIT_FLAG) && ((fl_r & mk_r) != '0)) begin
        we   = 1'b1;
        st_w = pst_pkg::ST_READY;
      end
    end
  end

  // Task table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        state_q[i]   <= pst_pkg::ST_READY;
        timeout_q[i] <= '0;
        flags_q[i]   <= '0;
        mask_q[i]    <= '0;
      end
    end else if (we) begin
      state_q[idx]   <= st_w;
      timeout_q[idx] <= to_w;
      flags_q[idx]   <= fl_w;
      mask_q[idx]    <= mk_w;
    end
  end

  // Scan pointer, current task and result.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load_ptr) begin
      ptr_d = highest_d;
    end else if (cmd_i.dec_ptr) begin
      ptr_d = ptr_q - IdW'(1);
    end
    cur_d = cur_q;
    rsp_d = rsp_q;
    if (cmd_i.finish_sel) begin
      cur_d                = {1'b0, ptr_q};
      rsp_d.next_task      = ptr_q;
      rsp_d.switch_request = ({1'b0, ptr_q} != cur_q);
      rsp_d.events         = '0;
    end else if (cmd_i.finish_nosel) begin
      rsp_d.next_task      = cur_id;
      rsp_d.switch_request = 1'b0;
      rsp_d.events         = ((req_q.func == pst_pkg::FUNC_COLLECT) && has_cur) ? fl_r : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      highest_q <= '0;
      cur_q     <= pst_pkg::NO_TASK;
      valid_q   <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      highest_q <= highest_d;
      cur_q     <= cur_d;
      valid_q   <= cmd_i.finish_sel || cmd_i.finish_nosel;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

FILE: hdl/priority_task_scheduler_unit.sv
// Sequence: an accepted transaction is latched and applied; add task and collect strobe
// their registered result, while other operations first run the priority scan from the
// highest task down; before its scan, a tick counts down timeouts from there to task 1.
// One task entry is visited per cycle; busy stays high until the result strobe.
// A new transaction waits for the last result; start is taken again in the strobe cycle.
// Reset: all tasks ready with cleared timeouts, flags and masks, and no current task.
module priority_task_scheduler_unit #(
  parameter int unsigned NumTasks = pst_pkg::NUM_TASKS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pst_pkg::pst_req_t req_i,
  output logic              result_valid_o,
  output pst_pkg::pst_rsp_t rsp_o
);

  pst_pkg::pst_cmd_t cmd;
  pst_pkg::pst_sts_t sts;

  // Operation sequencer.
  pst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Task table and result path.
  pst_datapath #(
    .NumTasks (NumTasks)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule

FILE: hdl/pst_checker.sv
// Port-level checks of the priority task scheduler, bound to the top level.
module pst_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input pst_pkg::pst_req_t req_i,
  input logic              result_valid_o,
  input pst_pkg::pst_rsp_t rsp_o
);

  // An accepted transaction keeps the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("unit not busy after an accepted transaction");

  // A result only appears once the unit has finished.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // Finishing a transaction always produces a result.
  a_fall_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  // Results never come on two consecutive cycles.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // Collected events come only from operations that make no selection.
  a_events_noswitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.events != '0)) |-> !rsp_o.switch_request)
    else $error("switch request together with collected events");

endmodule

bind priority_task_scheduler_unit pst_checker u_pst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

FILE: tb/priority_task_scheduler_checker.sv
`timescale 1ns / 1ps
// Checker that predicts scheduler results and compares them with the block's output.
module priority_task_scheduler_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  pst_pkg::pst_req_t req_i,
  input  logic              valid_i,
  input  pst_pkg::pst_rsp_t rsp_i,
  output int                fail_count_o,
  output int                pending_o
);
  import pst_pkg::*;

  // Predicted task table, mirroring what the scheduler holds.
  tstate_e          task_run   [MAX_IDS];
  logic [31:0]      task_delay [MAX_IDS];
  logic [31:0]      task_flags [MAX_IDS];
  logic [31:0]      task_mask  [MAX_IDS];
  logic [ID_W-1:0]  top_id;
  logic [CUR_W-1:0] running_id;

  // Scheduler decisions that are still to come out of the block.
  pst_rsp_t due_decisions [$];
  int       mismatches = 0;
  int       outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic logic id_valid(input int unsigned id);
    return (id < MAX_IDS) && (id < NUM_TASKS);
  endfunction

  // Priority scan from the highest added id down to 1; flag waiters whose
  // flags meet their mask are promoted on the way, and the scan stops at
  // the first ready task.
  function automatic logic [ID_W-1:0] pick_winner();
    for (int id = top_id; id > 0; id--) begin
      if (id_valid(id)) begin
        if (task_run[id] == ST_WAIT_FLAG && (task_flags[id] & task_mask[id]) != 32'd0) begin
          task_run[id] = ST_READY;
        end
        if (task_run[id] == ST_READY) begin
          return id[ID_W-1:0];
        end
      end
    end
    return '0;
  endfunction

  // Applies one scheduler call to the predicted table and returns its decision.
  function automatic pst_rsp_t schedule_step(input pst_req_t req);
    pst_rsp_t        decision;
    logic            has_cur;
    logic [ID_W-1:0] cur;
    logic            select;
    logic [ID_W-1:0] winner;
    has_cur  = id_valid(running_id);
    cur      = has_cur ? running_id[ID_W-1:0] : '0;
    decision = '0;
    select   = 1'b1;
    case (req.func)
      FUNC_ADD: begin
        if (id_valid(req.task_id)) begin
          if (req.task_id > top_id) begin
            top_id = req.task_id;
          end
          task_run[req.task_id]   = ST_READY;
          task_delay[req.task_id] = '0;
          task_flags[req.task_id] = '0;
          task_mask[req.task_id]  = '0;
        end
        select = 1'b0;
      end
      FUNC_SLEEP: begin
        if (has_cur) begin
          task_delay[cur] = req.wait_time;
          task_run[cur]   = ST_WAIT_TIME;
        end
      end
      FUNC_WAIT, FUNC_WAIT_TO: begin
        if (has_cur) begin
          task_mask[cur] = req.event_mask;
          if (req.func == FUNC_WAIT_TO) begin
            task_delay[cur] = req.wait_time;
          end
          task_run[cur] = ST_WAIT_FLAG;
        end
      end
      FUNC_SET: begin
        if (id_valid(req.task_id)) begin
          task_flags[req.task_id] |= req.event_mask;
        end
      end
      FUNC_TICK: begin
        // A zero timeout never counts, so a zero sleep waits forever.
        for (int id = top_id; id > 0; id--) begin
          if (id_valid(id) && task_delay[id] != 32'd0) begin
            task_delay[id]--;
            if (task_delay[id] == 32'd0) begin
              task_run[id] = ST_READY;
            end
          end
        end
      end
      FUNC_RESCHED: begin
      end
      FUNC_COLLECT: begin
        if (has_cur) begin
          decision.events = task_flags[cur];
          task_flags[cur] &= ~task_mask[cur];
        end
        select = 1'b0;
      end
      default: begin
      end
    endcase
    if (select) begin
      winner                  = pick_winner();
      decision.next_task      = winner;
      decision.switch_request = ({1'b0, winner} != running_id);
      running_id              = {1'b0, winner};
    end else begin
      decision.next_task = cur;
    end
    return decision;
  endfunction

  // Compare each result with the oldest prediction, then predict any newly
  // accepted transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    pst_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_IDS; i++) begin
        task_run[i]   = ST_READY;
        task_delay[i] = '0;
        task_flags[i] = '0;
        task_mask[i]  = '0;
      end
      top_id     = '0;
      running_id = NO_TASK;
      due_decisions.delete();
      outstanding = 0;
    end else begin
      if (valid_i) begin
        if (due_decisions.size() == 0) begin
          $error("result with no transaction pending: next_task %0d", rsp_i.next_task);
          mismatches++;
        end else begin
          want = due_decisions.pop_front();
          if (rsp_i.next_task !== want.next_task) begin
            $error("next_task mismatch: expected %0d, actual %0d",
                   want.next_task, rsp_i.next_task);
            mismatches++;
          end
          if (rsp_i.switch_request !== want.switch_request) begin
            $error("switch_request mismatch: expected %0b, actual %0b",
                   want.switch_request, rsp_i.switch_request);
            mismatches++;
          end
          if (rsp_i.events !== want.events) begin
            $error("events mismatch: expected %08h, actual %08h", want.events, rsp_i.events);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        due_decisions.push_back(schedule_step(req_i));
      end
      outstanding = due_decisions.size();
    end
  end

endmodule

FILE: tb/priority_task_scheduler_unit_test.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, scheduler call stimulus and the final verdict.
module priority_task_scheduler_unit_test;
  import pst_pkg::*;

  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned RandomPerPhase = 285;
  localparam int unsigned SettleCycles   = 40;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  pst_req_t    req_i  = '0;
  logic        busy;
  logic        result_valid_o;
  pst_rsp_t    rsp_o;
  int          fail_count;
  int          pending;
  int unsigned cycle_count     = 0;
  int unsigned sender_idle_pct = 38;

  priority_task_scheduler_unit uut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .result_valid_o,
    .rsp_o
  );

  priority_task_scheduler_checker sched_check (
    .clk_i,
    .rst_ni,
    .start_i      (start),
    .busy_i       (busy),
    .req_i,
    .valid_i      (result_valid_o),
    .rsp_i        (rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("priority_task_scheduler_unit_test failed");
      $finish;
    end
  end

  // Presents one scheduler call, with a random gap first, and holds it until
  // the block takes the transaction.
  task automatic issue(input func_e op, input logic [ID_W-1:0] id,
                       input logic [31:0] mask, input logic [31:0] ticks);
    pst_req_t item;
    item.func       = op;
    item.task_id    = id;
    item.event_mask = mask;
    item.wait_time  = ticks;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops sending until every predicted result has come out.
  task automatic wait_all_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Random call mix: mostly sleeps, waits, flag sets and ticks with short
  // timeouts and narrow masks, so tasks keep waking and blocking.
  function automatic pst_req_t random_call();
    pst_req_t    item;
    int unsigned pick;
    int unsigned mask_kind;
    pick      = $urandom_range(0, 99);
    mask_kind = $urandom_range(0, 3);
    item.task_id = ID_W'($urandom_range(0, 7));
    if (mask_kind == 0) begin
      item.event_mask = $urandom;
    end else if (mask_kind == 1) begin
      item.event_mask = 32'd1 << $urandom_range(0, 31);
    end else begin
      item.event_mask = $urandom_range(1, 15);
    end
    item.wait_time = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : $urandom;
    if (pick < 8) begin
      item.func = FUNC_ADD;
    end else if (pick < 22) begin
      item.func = FUNC_SLEEP;
    end else if (pick < 32) begin
      item.func = FUNC_WAIT;
    end else if (pick < 42) begin
      item.func = FUNC_WAIT_TO;
    end else if (pick < 60) begin
      item.func = FUNC_SET;
    end else if (pick < 82) begin
      item.func = FUNC_TICK;
    end else if (pick < 90) begin
      item.func = FUNC_RESCHED;
    end else begin
      item.func = FUNC_COLLECT;
    end
    return item;
  endfunction

  // Main sequence.
  initial begin
    pst_req_t item;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // No current task: collect gives zero; sleep just selects the idle task.
    issue(FUNC_COLLECT, 3'd0, 32'hFFFF_FFFF, 32'd0);
    issue(FUNC_SLEEP, 3'd7, 32'd0, 32'd5);
    // The idle task waits, yet stays the fallback.
    issue(FUNC_WAIT_TO, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(FUNC_ADD, 3'd3, 32'd0, 32'd0);
    issue(FUNC_RESCHED, 3'd0, 32'd0, 32'd0);
    issue(FUNC_SET, 3'd3, 32'hFFFF_FFFF, 32'd0);
    issue(FUNC_COLLECT, 3'd0, 32'd0, 32'd0);
    issue(FUNC_ADD, 3'd7, 32'd0, 32'd0);
    issue(FUNC_ADD, 3'd5, 32'd0, 32'd0);
    issue(FUNC_RESCHED, 3'd0, 32'd0, 32'd0);
    // A zero sleep time never expires.
    issue(FUNC_SLEEP, 3'd0, 32'd0, 32'd0);
    issue(FUNC_WAIT_TO, 3'd0, 32'h8000_0000, 32'd2);
    issue(FUNC_WAIT, 3'd0, 32'h0000_0001, 32'd0);
    issue(FUNC_SET, 3'd5, 32'h8000_0000, 32'd0);
    issue(FUNC_COLLECT, 3'd0, 32'd0, 32'd0);
    issue(FUNC_SLEEP, 3'd0, 32'd0, 32'hFFFF_FFFF);
    // A ready task above stops the scan before a satisfied waiter below it.
    issue(FUNC_ADD, 3'd7, 32'd0, 32'd0);
    issue(FUNC_SET, 3'd3, 32'h0000_0001, 32'd0);
    issue(FUNC_SLEEP, 3'd0, 32'd0, 32'd1);
    issue(FUNC_TICK, 3'd0, 32'd0, 32'd0);
    issue(FUNC_SET, 3'd0, 32'hFFFF_FFFF, 32'd0);
    issue(FUNC_TICK, 3'd0, 32'd0, 32'd0);
    issue(FUNC_ADD, 3'd0, 32'd0, 32'd0);
    issue(FUNC_WAIT_TO, 3'd0, 32'd0, 32'd0);
    issue(FUNC_RESCHED, 3'd0, 32'd0, 32'd0);
    wait_all_results();

    // Random calls in three phases of sender idling.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 86 : 0;
      for (int n = 0; n < RandomPerPhase; n++) begin
        item = random_call();
        issue(item.func, item.task_id, item.event_mask, item.wait_time);
        if (n == RandomPerPhase / 2) begin
          wait_all_results();
        end
      end
      wait_all_results();
    end

    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("priority_task_scheduler_unit_test passed");
    end else begin
      $display("priority_task_scheduler_unit_test failed");
    end
    $finish;
  end

endmodule
